@@ rtl/ddgo_pkg.sv @@
`default_nettype none
package ddgo_pkg;

	localparam int DEF_TRIG_FRAC_BITS = 16;
	localparam int DEF_POSE_BITS      = 40;

	localparam logic [15:0] DIST_RESET = 16'd915;

	// Shared multiplier operand and product widths.
	localparam int MA = 40;
	localparam int MB = 33;
	localparam int PW = MA + MB;

	// Step length, local step and global step widths.
	localparam int DW  = 38;
	localparam int LW  = 39;
	localparam int DXW = 41;

	// Reciprocal for the quadrant split: floor(u / 9000) = (u * Q_MAGIC) >> 32 for u < 2^18.
	localparam logic [19:0] Q_MAGIC = 20'd477219;
	// PI in Q30 split as 18000 * PI_HI + PI_LO.
	localparam logic [17:0] PI_HI   = 18'd187403;
	localparam logic [12:0] PI_LO   = 13'd5426;
	// floor(n / 18000) = (n * X_MAGIC) >> 40 for n < 2^25.
	localparam logic [25:0] X_MAGIC = 26'd61083980;

	localparam int NDIV = 9;
	// Horner divisors 72, 42, 20, 6 (sine) and 90, 56, 30, 12, 2 (cosine), exact for values below 2^31.
	localparam logic [31:0] DIV_MAGIC [NDIV] = '{
		32'd3817748708, 32'd3272356036, 32'd3435973837, 32'd2863311531,
		32'd3054198967, 32'd2454267027, 32'd2290649225, 32'd2863311531,
		32'd2147483648
	};
	localparam logic [5:0] DIV_SHIFT [NDIV] = '{
		6'd38, 6'd37, 6'd36, 6'd34, 6'd38, 6'd37, 6'd36, 6'd35, 6'd32
	};

	typedef enum logic [4:0] {
		OP_NOP, OP_LOAD, OP_SUM, OP_DMUL, OP_DRND,
		OP_QMUL, OP_QFIX, OP_XMUL, OP_XDIV, OP_XFIN, OP_TMUL, OP_TRND,
		OP_DIVMUL, OP_DIVFIN, OP_MTS, OP_MXS, OP_XSFIN, OP_TRIG,
		OP_P1, OP_P2, OP_P3, OP_P4, OP_P5, OP_P6, OP_P7, OP_P8, OP_OUT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] k;     // divisor select
		logic       dst;   // 0: sine term, 1: cosine term
		logic       first; // first Horner step divides t itself
		logic       sel;   // 0: heading change, 1: heading
	} cmd_t;

endpackage
`default_nettype wire

@@ rtl/diff_drive_gyro_odometry.sv @@
`default_nettype none
// Dead-reckoning odometry for a differential drive with a gyro heading. Each input transfer
// carries four wheel encoder positions and a yaw; each one yields one output transfer with the
// saturating global x and y (Q24.16 inches) and the heading. Nearly all of the work on an
// item is done in one shared multiplier that steps through the step length, two sine/cosine
// evaluations (quadrant split, radians and Horner series) and the rotation into global
// coordinates. A new item is taken once the last one has moved into the output register, so a
// result left waiting does not stall the input unless the next one finishes before it is
// taken. dist_per_count sits at address 0 of the register port and may be changed only while
// the block is idle.
module diff_drive_gyro_odometry
	import ddgo_pkg::*;
#(
	parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS,
	parameter int POSE_BITS      = DEF_POSE_BITS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// enc_right_front, enc_right_back, enc_left_front, enc_left_back, yaw
	input  wire logic [143:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// x_pose, y_pose, heading
	output logic      [95:0]  m_tdata
);

	logic [15:0]        dist_q;
	cmd_t               cmd;
	logic signed [39:0] x_pose, y_pose;
	logic signed [15:0] heading;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {16'd0, dist_q} : 32'd0;

	// Low address bits are ignored: only paddr[2] is decoded, so addresses 0 to 3 reach the register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= DIST_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			dist_q <= pwdata[15:0];
		end
	end

	ddgo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	ddgo_dp #(
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS),
		.POSE_BITS      (POSE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.enc_right_front (s_tdata[31:0]),
		.enc_right_back  (s_tdata[63:32]),
		.enc_left_front  (s_tdata[95:64]),
		.enc_left_back   (s_tdata[127:96]),
		.yaw             (s_tdata[143:128]),
		.dist_per_count  (dist_q),
		.x_pose          (x_pose),
		.y_pose          (y_pose),
		.heading         (heading)
	);

	assign m_tdata = {heading, y_pose, x_pose};

endmodule
`default_nettype wire

@@ rtl/ddgo_ctrl.sv @@
`default_nettype none
module ddgo_ctrl
	import ddgo_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {ST_IDLE, ST_PRE, ST_TRIG, ST_POSE, ST_OUT} state_t;

	localparam logic [5:0] PRE_LAST  = 6'd2;
	localparam logic [5:0] TRIG_LAST = 6'd34;
	localparam logic [5:0] POSE_LAST = 6'd7;

	state_t     state_q;
	logic [5:0] step_q;
	logic       pass_q;
	logic       out_valid_q;
	logic       issue_out;

	function automatic cmd_t mk(op_t op, logic [3:0] k, logic dst, logic first);
		cmd_t c;
		c.op    = op;
		c.k     = k;
		c.dst   = dst;
		c.first = first;
		c.sel   = 1'b0;
		return c;
	endfunction

	// One sine/cosine evaluation: angle reduction, radians, then two Horner chains.
	function automatic cmd_t trig_cmd(logic [5:0] s);
		cmd_t c;
		c = mk(OP_NOP, 4'd0, 1'b0, 1'b0);
		case (s)
			6'd0:  c = mk(OP_QMUL,   4'd0, 1'b0, 1'b0);
			6'd1:  c = mk(OP_QFIX,   4'd0, 1'b0, 1'b0);
			6'd2:  c = mk(OP_XMUL,   4'd0, 1'b0, 1'b0);
			6'd3:  c = mk(OP_XDIV,   4'd0, 1'b0, 1'b0);
			6'd4:  c = mk(OP_XFIN,   4'd0, 1'b0, 1'b0);
			6'd5:  c = mk(OP_TMUL,   4'd0, 1'b0, 1'b0);
			6'd6:  c = mk(OP_TRND,   4'd0, 1'b0, 1'b0);
			6'd7:  c = mk(OP_DIVMUL, 4'd0, 1'b0, 1'b1);
			6'd8:  c = mk(OP_DIVFIN, 4'd0, 1'b0, 1'b0);
			6'd9:  c = mk(OP_MTS,    4'd0, 1'b0, 1'b0);
			6'd10: c = mk(OP_DIVMUL, 4'd1, 1'b0, 1'b0);
			6'd11: c = mk(OP_DIVFIN, 4'd1, 1'b0, 1'b0);
			6'd12: c = mk(OP_MTS,    4'd0, 1'b0, 1'b0);
			6'd13: c = mk(OP_DIVMUL, 4'd2, 1'b0, 1'b0);
			6'd14: c = mk(OP_DIVFIN, 4'd2, 1'b0, 1'b0);
			6'd15: c = mk(OP_MTS,    4'd0, 1'b0, 1'b0);
			6'd16: c = mk(OP_DIVMUL, 4'd3, 1'b0, 1'b0);
			6'd17: c = mk(OP_DIVFIN, 4'd3, 1'b0, 1'b0);
			6'd18: c = mk(OP_MXS,    4'd0, 1'b0, 1'b0);
			6'd19: c = mk(OP_XSFIN,  4'd0, 1'b0, 1'b0);
			6'd20: c = mk(OP_DIVMUL, 4'd4, 1'b1, 1'b1);
			6'd21: c = mk(OP_DIVFIN, 4'd4, 1'b1, 1'b0);
			6'd22: c = mk(OP_MTS,    4'd0, 1'b1, 1'b0);
			6'd23: c = mk(OP_DIVMUL, 4'd5, 1'b1, 1'b0);
			6'd24: c = mk(OP_DIVFIN, 4'd5, 1'b1, 1'b0);
			6'd25: c = mk(OP_MTS,    4'd0, 1'b1, 1'b0);
			6'd26: c = mk(OP_DIVMUL, 4'd6, 1'b1, 1'b0);
			6'd27: c = mk(OP_DIVFIN, 4'd6, 1'b1, 1'b0);
			6'd28: c = mk(OP_MTS,    4'd0, 1'b1, 1'b0);
			6'd29: c = mk(OP_DIVMUL, 4'd7, 1'b1, 1'b0);
			6'd30: c = mk(OP_DIVFIN, 4'd7, 1'b1, 1'b0);
			6'd31: c = mk(OP_MTS,    4'd0, 1'b1, 1'b0);
			6'd32: c = mk(OP_DIVMUL, 4'd8, 1'b1, 1'b0);
			6'd33: c = mk(OP_DIVFIN, 4'd8, 1'b1, 1'b0);
			6'd34: c = mk(OP_TRIG,   4'd0, 1'b0, 1'b0);
			default: c = mk(OP_NOP,  4'd0, 1'b0, 1'b0);
		endcase
		return c;
	endfunction

	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign issue_out = (state_q == ST_OUT) && (!out_valid_q || m_tready);

	always_comb begin
		cmd = mk(OP_NOP, 4'd0, 1'b0, 1'b0);
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) cmd.op = OP_LOAD;
			end
			ST_PRE: begin
				case (step_q)
					6'd0:    cmd.op = OP_SUM;
					6'd1:    cmd.op = OP_DMUL;
					default: cmd.op = OP_DRND;
				endcase
			end
			ST_TRIG: begin
				cmd     = trig_cmd(step_q);
				cmd.sel = pass_q;
			end
			ST_POSE: begin
				case (step_q)
					6'd0:    cmd.op = OP_P1;
					6'd1:    cmd.op = OP_P2;
					6'd2:    cmd.op = OP_P3;
					6'd3:    cmd.op = OP_P4;
					6'd4:    cmd.op = OP_P5;
					6'd5:    cmd.op = OP_P6;
					6'd6:    cmd.op = OP_P7;
					default: cmd.op = OP_P8;
				endcase
			end
			ST_OUT: begin
				if (issue_out) cmd.op = OP_OUT;
			end
			default: cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue_out) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_PRE;
						step_q  <= '0;
					end
				end
				ST_PRE: begin
					if (step_q == PRE_LAST) begin
						state_q <= ST_TRIG;
						step_q  <= '0;
						pass_q  <= 1'b0;
					end else begin
						step_q <= step_q + 6'd1;
					end
				end
				ST_TRIG: begin
					if (step_q == TRIG_LAST) begin
						step_q <= '0;
						if (pass_q) state_q <= ST_POSE;
						pass_q <= ~pass_q;
					end else begin
						step_q <= step_q + 6'd1;
					end
				end
				ST_POSE: begin
					if (step_q == POSE_LAST) state_q <= ST_OUT;
					else step_q <= step_q + 6'd1;
				end
				ST_OUT: begin
					if (issue_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/ddgo_dp.sv @@
`default_nettype none
module ddgo_dp
	import ddgo_pkg::*;
#(
	parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS,
	parameter int POSE_BITS      = DEF_POSE_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	input  wire logic signed [31:0] enc_right_front,
	input  wire logic signed [31:0] enc_right_back,
	input  wire logic signed [31:0] enc_left_front,
	input  wire logic signed [31:0] enc_left_back,
	input  wire logic signed [15:0] yaw,
	input  wire logic        [15:0] dist_per_count,
	output logic signed      [39:0] x_pose,
	output logic signed      [39:0] y_pose,
	output logic signed      [15:0] heading
);

	localparam int F   = TRIG_FRAC_BITS;
	localparam int PB  = POSE_BITS;
	localparam int TW  = F + 2;
	localparam int SH  = 30 - F;
	localparam int SW  = ((PB > DXW) ? PB : DXW) + 1;

	localparam logic signed [PW-1:0] HALF_F  = PW'(1) << (F - 1);
	localparam logic signed [PW-1:0] HALF_2  = PW'(2);
	localparam logic signed [PW-1:0] D_MAX   = PW'({1'b0, {(DW - 1){1'b1}}});
	localparam logic signed [PW-1:0] D_MIN   = -D_MAX - PW'(1);
	localparam logic        [PW-1:0] HALF_30 = PW'(1) << 29;
	localparam logic        [31:0]   HALF_T  = 32'(1) << (SH - 1);
	localparam logic        [30:0]   ONE     = 31'(1) << 30;
	localparam logic        [17:0]   BIAS    = 18'd76500;
	localparam logic        [17:0]   QSTEP   = 18'd9000;
	localparam logic        [17:0]   HALFQ   = 18'd4500;
	localparam logic        [25:0]   XRND    = 26'd9000;
	localparam logic signed [SW-1:0] P_MAX   = {{(SW - PB + 1){1'b0}}, {(PB - 1){1'b1}}};
	localparam logic signed [SW-1:0] P_MIN   = {{(SW - PB + 1){1'b1}}, {(PB - 1){1'b0}}};

	logic signed [33:0]    rsum_q, lsum_q, prev_r_q, prev_l_q;
	logic signed [15:0]    h_q, prev_h_q;
	logic signed [35:0]    sum2_q;
	logic signed [PW-1:0]  prod_q, acc_q;
	logic signed [DW-1:0]  d_q;
	logic        [1:0]     quad_q;
	logic                  neg_q;
	logic        [12:0]    ra_q;
	logic        [29:0]    xr_q;
	logic        [30:0]    t_q, s_q, c_q;
	logic signed [TW-1:0]  sdh_q, cdh_q, sh_q, ch_q;
	logic signed [LW-1:0]  dxl_q, dyl_q;
	logic signed [DXW-1:0] dx_q, dy_q;
	logic signed [PB-1:0]  x_q, y_q;
	logic        [39:0]    xo_q, yo_q;
	logic        [15:0]    ho_q;

	logic signed [MA-1:0]  mul_a;
	logic signed [MB-1:0]  mul_b;
	logic signed [PW-1:0]  mul_p;
	logic signed [16:0]    ang;
	logic signed [18:0]    u_w;
	logic        [17:0]    u;
	logic        [17:0]    rem;
	logic        [30:0]    qd;
	logic signed [PW-1:0]  r_d, r_f, r_dx, r_dy;
	logic        [PW-1:0]  t_sum;
	logic signed [TW-1:0]  sv, cv, svn, sn_n, cs_n;
	logic signed [SW-1:0]  xsum, ysum, xsat, ysat;
	logic signed [63:0]    xe, ye;

	assign ang = cmd.sel ? 17'(h_q) : (17'(h_q) - 17'(prev_h_q));
	assign u_w = 19'(ang) + 19'(BIAS);
	assign u   = u_w[17:0];
	assign rem = u - (18'(prod_q[36:32]) * QSTEP);
	assign qd  = 31'(prod_q >> DIV_SHIFT[cmd.k]);

	assign r_d   = (prod_q + HALF_2) >>> 2;
	assign r_f   = (prod_q + HALF_F) >>> F;
	assign r_dx  = ((acc_q - prod_q) + HALF_F) >>> F;
	assign r_dy  = ((acc_q + prod_q) + HALF_F) >>> F;
	assign t_sum = prod_q + HALF_30;

	assign sv  = TW'((32'(s_q) + HALF_T) >> SH);
	assign cv  = TW'((32'(c_q) + HALF_T) >> SH);
	assign svn = neg_q ? -sv : sv;

	always_comb begin
		case (quad_q)
			2'd0:    begin sn_n = svn;  cs_n = cv;   end
			2'd1:    begin sn_n = cv;   cs_n = -svn; end
			2'd2:    begin sn_n = -svn; cs_n = -cv;  end
			default: begin sn_n = -cv;  cs_n = svn;  end
		endcase
	end

	assign xsum = SW'(x_q) + SW'(dx_q);
	assign ysum = SW'(y_q) + SW'(dy_q);
	assign xsat = (xsum > P_MAX) ? P_MAX : ((xsum < P_MIN) ? P_MIN : xsum);
	assign ysat = (ysum > P_MAX) ? P_MAX : ((ysum < P_MIN) ? P_MIN : ysum);
	assign xe   = 64'(x_q);
	assign ye   = 64'(y_q);

	// The shared multiplier; its products land in prod_q (the PI_HI and remainder products are separate).
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_DMUL: begin
				mul_a = MA'(sum2_q);
				mul_b = MB'({1'b0, dist_per_count});
			end
			OP_QMUL: begin
				mul_a = MA'(u);
				mul_b = MB'(Q_MAGIC);
			end
			OP_XMUL: begin
				mul_a = MA'(ra_q);
				mul_b = MB'(PI_LO);
			end
			OP_XDIV: begin
				mul_a = MA'(26'(prod_q[24:0]) + XRND);
				mul_b = MB'(X_MAGIC);
			end
			OP_TMUL: begin
				mul_a = MA'(xr_q);
				mul_b = MB'(xr_q);
			end
			OP_DIVMUL: begin
				mul_a = cmd.first ? MA'(t_q) : MA'(prod_q[60:30]);
				mul_b = MB'(DIV_MAGIC[cmd.k]);
			end
			OP_MTS: begin
				mul_a = MA'(t_q);
				mul_b = cmd.dst ? MB'(c_q) : MB'(s_q);
			end
			OP_MXS: begin
				mul_a = MA'(xr_q);
				mul_b = MB'(s_q);
			end
			OP_P1: begin
				mul_a = MA'(d_q);
				mul_b = MB'(sdh_q);
			end
			OP_P2: begin
				mul_a = MA'(d_q);
				mul_b = MB'(cdh_q);
			end
			OP_P3: begin
				mul_a = MA'(dxl_q);
				mul_b = MB'(ch_q);
			end
			OP_P4: begin
				mul_a = MA'(dyl_q);
				mul_b = MB'(sh_q);
			end
			OP_P5: begin
				mul_a = MA'(dxl_q);
				mul_b = MB'(sh_q);
			end
			OP_P6: begin
				mul_a = MA'(dyl_q);
				mul_b = MB'(ch_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_r_q <= '0;
			prev_l_q <= '0;
			prev_h_q <= '0;
			x_q      <= '0;
			y_q      <= '0;
		end else begin
			if (cmd.op == OP_P6) x_q <= PB'(xsat);
			if (cmd.op == OP_P8) begin
				y_q      <= PB'(ysat);
				prev_r_q <= rsum_q;
				prev_l_q <= lsum_q;
				prev_h_q <= h_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				rsum_q <= -(34'(enc_right_front) + 34'(enc_right_back));
				lsum_q <= -(34'(enc_left_front) + 34'(enc_left_back));
				h_q    <= yaw;
			end
			OP_SUM:  sum2_q <= (36'(rsum_q) - 36'(prev_r_q)) + (36'(lsum_q) - 36'(prev_l_q));
			OP_DRND: d_q <= (r_d > D_MAX) ? DW'(D_MAX) : ((r_d < D_MIN) ? DW'(D_MIN) : DW'(r_d));
			OP_QFIX: begin
				quad_q <= prod_q[33:32];
				neg_q  <= (rem < HALFQ);
				ra_q   <= (rem < HALFQ) ? 13'(HALFQ - rem) : 13'(rem - HALFQ);
			end
			OP_XMUL: xr_q <= 30'(ra_q) * 30'(PI_HI);
			OP_XFIN: xr_q <= xr_q + 30'(prod_q[50:40]);
			OP_TRND: t_q  <= t_sum[60:30];
			OP_DIVFIN: begin
				if (cmd.dst) c_q <= ONE - qd;
				else s_q <= ONE - qd;
			end
			OP_XSFIN: s_q <= prod_q[60:30];
			OP_TRIG: begin
				if (cmd.sel) begin
					sh_q <= sn_n;
					ch_q <= cs_n;
				end else begin
					sdh_q <= sn_n;
					cdh_q <= cs_n;
				end
			end
			OP_P2: dxl_q <= LW'(r_f);
			OP_P3: dyl_q <= LW'(r_f);
			OP_P4: acc_q <= prod_q;
			OP_P5: dx_q  <= DXW'(r_dx);
			OP_P6: acc_q <= prod_q;
			OP_P7: dy_q  <= DXW'(r_dy);
			OP_OUT: begin
				xo_q <= xe[39:0];
				yo_q <= ye[39:0];
				ho_q <= h_q;
			end
			default: ;
		endcase
		if (cmd.op != OP_NOP && cmd.op != OP_LOAD && cmd.op != OP_OUT) prod_q <= mul_p;
	end

	assign x_pose  = xo_q;
	assign y_pose  = yo_q;
	assign heading = ho_q;

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none

class odometry_scoreboard;
	logic [15:0] dist_per_count;
	longint prev_right_sum, prev_left_sum, prev_heading, x_acc, y_acc;
	logic [95:0] pose_q[$];
	int errors;
	int checked;

	function void clear();
		dist_per_count = ddgo_pkg::DIST_RESET;
		prev_right_sum = 0;
		prev_left_sum = 0;
		prev_heading = 0;
		x_acc = 0;
		y_acc = 0;
	endfunction

	function longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function longint limit(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim - 1) return -lim - 1;
		return v;
	endfunction

	function longint trig_round(longint unsigned q30);
		return longint'((q30 + (64'd1 << 13)) >> 14);
	endfunction

	// Angle in hundredths of a degree, reduced about the nearest quadrant.
	function void sin_cos(longint a, output longint sn, output longint cs);
		longint unsigned u, q, ra, x, t, s, c;
		longint r, sv, cv;
		u = a + 76500;
		q = u / 9000;
		r = longint'(u - q * 9000) - 4500;
		ra = (r < 0) ? -r : r;
		x = (ra * 64'd3373259426 + 9000) / 18000;
		t = (x * x + (64'd1 << 29)) >> 30;
		s = (64'd1 << 30) - t / 72;
		s = (64'd1 << 30) - ((t * s) >> 30) / 42;
		s = (64'd1 << 30) - ((t * s) >> 30) / 20;
		s = (64'd1 << 30) - ((t * s) >> 30) / 6;
		s = (x * s) >> 30;
		c = (64'd1 << 30) - t / 90;
		c = (64'd1 << 30) - ((t * c) >> 30) / 56;
		c = (64'd1 << 30) - ((t * c) >> 30) / 30;
		c = (64'd1 << 30) - ((t * c) >> 30) / 12;
		c = (64'd1 << 30) - ((t * c) >> 30) / 2;
		sv = trig_round(s);
		cv = trig_round(c);
		if (r < 0) sv = -sv;
		case (q & 3)
			0: begin sn = sv; cs = cv; end
			1: begin sn = cv; cs = -sv; end
			2: begin sn = -sv; cs = -cv; end
			default: begin sn = -cv; cs = sv; end
		endcase
	endfunction

	function void note_tick(logic [143:0] d);
		longint rsum, lsum, step_len, h, dh, sdh, cdh, sh, ch, dxl, dyl, dx, dy;
		logic [95:0] p;
		rsum = -(longint'($signed(d[31:0])) + longint'($signed(d[63:32])));
		lsum = -(longint'($signed(d[95:64])) + longint'($signed(d[127:96])));
		h = longint'($signed(d[143:128]));
		step_len = round_shift(((rsum - prev_right_sum) + (lsum - prev_left_sum))
			* longint'(dist_per_count), 2);
		step_len = limit(step_len, (longint'(1) << 37) - 1);
		dh = h - prev_heading;
		sin_cos(dh, sdh, cdh);
		sin_cos(h, sh, ch);
		dxl = round_shift(step_len * sdh, 16);
		dyl = round_shift(step_len * cdh, 16);
		dx = round_shift(dxl * ch - dyl * sh, 16);
		dy = round_shift(dxl * sh + dyl * ch, 16);
		x_acc = limit(x_acc + dx, (longint'(1) << 39) - 1);
		y_acc = limit(y_acc + dy, (longint'(1) << 39) - 1);
		prev_heading = h;
		prev_right_sum = rsum;
		prev_left_sum = lsum;
		p = {h[15:0], y_acc[39:0], x_acc[39:0]};
		pose_q.push_back(p);
	endfunction

	task report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		if (errors <= 30)
			$display("mismatch %s: got %h want %h (pose %0d)", what, got, want, checked);
	endtask

	task check_pose(logic [95:0] got);
		logic [95:0] want;
		if (pose_q.size() == 0) begin
			report("unexpected transfer", got[63:0], 0);
			return;
		end
		want = pose_q.pop_front();
		if (got[39:0] !== want[39:0]) report("x_pose", got[39:0], want[39:0]);
		if (got[79:40] !== want[79:40]) report("y_pose", got[79:40], want[79:40]);
		if (got[95:80] !== want[95:80]) report("heading", got[95:80], want[95:80]);
		checked++;
	endtask
endclass

module testbench;
	import ddgo_pkg::*;

	localparam logic [2:0] ADDR_DIST_PER_COUNT = 3'd0;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [143:0] s_tdata;
	logic [95:0] m_tdata;
	longint cycle;
	int ticks_sent;
	logic stall_free;
	odometry_scoreboard sb;

	diff_drive_gyro_odometry dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	task automatic write_dist(logic [15:0] v);
		@(negedge clk);
		psel <= 1; pwrite <= 1; paddr <= ADDR_DIST_PER_COUNT; pwdata <= {16'h0, v};
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		sb.dist_per_count = v;
	endtask

	task automatic wait_drained();
		while (sb.pose_q.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic send_tick(logic [31:0] rf, rb, lf, lb, logic [15:0] yaw);
		int g;
		@(negedge clk);
		g = stall_free ? 0 : gap_len();
		repeat (g) @(negedge clk);
		s_tdata <= {yaw, lb, lf, rb, rf};
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		sb.note_tick({yaw, lb, lf, rb, rf});
		ticks_sent++;
		@(negedge clk);
		s_tvalid <= 0;
	endtask

	function logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom();
			default: return 32'($signed($urandom_range(0, 4000)) - 2000);
		endcase
	endfunction

	function logic [15:0] rand_yaw();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return $urandom();
		if (r == 1) return $urandom_range(0, 1) ? 16'sd18000 : -16'sd18000;
		return 16'($signed($urandom_range(0, 36000)) - 18000);
	endfunction

	// Output side: random stalls, sampled at the rising edge.
	initial begin
		int g;
		m_tready = 0;
		forever begin
			@(negedge clk);
			g = stall_free ? 0 : gap_len();
			if (g > 0) begin
				m_tready <= 0;
				repeat (g) @(negedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_pose(m_tdata);
		end
	end

	initial begin
		cycle = 0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle > 3000000) begin
				$display("timeout at cycle %0d", cycle);
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] e0, e1, e2, e3;
		int pos;
		sb = new();
		sb.clear();
		stall_free = 0;
		ticks_sent = 0;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		s_tvalid = 0; s_tdata = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: reset distance, yaw extremes, out-of-range yaw, encoder extremes.
		send_tick(0, 0, 0, 0, 0);
		send_tick(-100, -100, -100, -100, 16'sd9000);
		send_tick(-101, -100, -100, -99, 16'sd18000);
		send_tick(100, 100, 101, 100, -16'sd18000);
		send_tick(0, 0, 0, 0, 16'h7fff);
		send_tick(0, 0, 0, 0, 16'h8000);
		send_tick(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'sd4500);
		send_tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -16'sd4500);
		send_tick(32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h0, 16'hffff);
		wait_drained();
		write_dist(16'hffff);
		// Large steps with the widest scale to drive the pose into saturation.
		for (int i = 0; i < 10; i++)
			send_tick(i[0] ? 32'h8000_0000 : 32'h7fff_ffff, i[0] ? 32'h8000_0000 : 32'h7fff_ffff,
				i[0] ? 32'h8000_0000 : 32'h7fff_ffff, i[0] ? 32'h8000_0000 : 32'h7fff_ffff,
				16'(i * 4500));
		// Hold off until every pose has come back.
		wait_drained();
		write_dist(16'h0);
		send_tick(5, 6, 7, 8, 16'sd100);
		send_tick(-5, 9, 70, 8, 16'sd200);

		for (int phase = 0; phase < 4; phase++) begin
			wait_drained();
			case (phase)
				0: write_dist(16'd915);
				1: write_dist($urandom());
				2: write_dist(16'd1);
				default: write_dist(16'hffff);
			endcase
			stall_free = (phase == 2);
			pos = 0;
			for (int i = 0; i < 345; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					e0 = rand_word(); e1 = rand_word(); e2 = rand_word(); e3 = rand_word();
				end else begin
					// Smooth driving: encoders creep, yaw is drawn at random.
					pos += $signed($urandom_range(0, 400)) - 200;
					e0 = -pos + $urandom_range(0, 3);
					e1 = -pos;
					e2 = -pos - $urandom_range(0, 3);
					e3 = -pos + $urandom_range(0, 1);
				end
				send_tick(e0, e1, e2, e3, rand_yaw());
			end
		end
		stall_free = 0;
		wait_drained();
		$display("covered %0d ticks, %0d poses checked, scale settings 915/ffff/0/1/random",
			ticks_sent, sb.checked);
		if (sb.errors == 0 && sb.pose_q.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule

@@ files.f @@
rtl/ddgo_pkg.sv
rtl/ddgo_ctrl.sv
rtl/ddgo_dp.sv
rtl/diff_drive_gyro_odometry.sv
dv/testbench.sv
